[hdl/sbdf_pkg.sv]
// Shared definitions for the shared-buffer dual FIFO: sizes, mode and status
// codes, and the per-cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbdf_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_ENQ    = 3'd0,
		MODE_DEQ    = 3'd1,
		MODE_PEEK   = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_SEARCH = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic load;        // write the key into this slot
		logic take_right;  // forward dequeue: move right neighbor in
		logic take_left;   // reverse dequeue: move left neighbor in
		logic in_fwd;      // slot lies in the forward region
		logic in_rev;      // slot lies in the reverse region
	} cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/shared_buffer_dual_fifo.sv]
// Top level of the shared-buffer dual FIFO: count registers, per-cell
// control decode, the row of slot cells, search priority and result register.
// Depends on sbdf_pkg and sbdf_cell.
`timescale 1ns / 1ps
`default_nettype none

// Two queues share one row of slot cells: the forward queue grows up from
// slot 0, the reverse queue grows down from slot capacity-1. Every
// operation (enqueue, dequeue, peek, clear, search) completes in the cycle
// its item is accepted, since all cells shift and compare in parallel; the
// result is captured in the output register; a new item is accepted every
// cycle unless that register is stalled. Rate is one item per cycle when not
// stalled, set by the parallel cell update and the 16-way search priority
// encoder. Write capacity only while idle and issue a clear after.

module shared_buffer_dual_fifo (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [sbdf_pkg::CNT_W-1:0]     cfg_data,
	// input items
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [2:0]                     mode,
	input  wire                            side,
	input  wire  [sbdf_pkg::DATA_W-1:0]    data_in,
	// result items
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [sbdf_pkg::DATA_W-1:0]    data_out,
	output logic [1:0]                     status,
	output logic [sbdf_pkg::IDX_W-1:0]     found_index,
	output logic                           found_side,
	output logic [sbdf_pkg::CNT_W-1:0]     forward_count,
	output logic [sbdf_pkg::CNT_W-1:0]     reverse_count
);
	import sbdf_pkg::*;

	logic [CNT_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  fwd_q, rev_q;
	logic [CNT_W-1:0]  fwd_d, rev_d;
	logic              out_valid_q;
	logic [DATA_W-1:0] data_out_q;
	status_t           status_q;
	logic [IDX_W-1:0]  found_index_q;
	logic              found_side_q;
	logic [CNT_W-1:0]  fwd_out_q, rev_out_q;

	logic              acc;
	logic [CNT_W-1:0]  cap, cap_m1, fend, rlo, rev_wr;
	logic              full, enq_ok, deq_fwd, deq_rev;
	mode_t             op;

	cell_ctrl_t        ctrl  [DEPTH];
	logic [DATA_W-1:0] val   [DEPTH];
	logic [DATA_W-1:0] lval  [DEPTH];
	logic [DATA_W-1:0] rval  [DEPTH];
	logic [DEPTH-1:0]  hit;

	logic [DATA_W-1:0] data_d;
	status_t           status_d;
	logic [IDX_W-1:0]  fidx_d;
	logic              fside_d;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign acc       = in_valid & ~in_stall;
	assign op        = mode_t'(mode);

	// clamp capacity to 1..DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap = CNT_W'(1);
		end else if (capacity_q > CNT_W'(DEPTH)) begin
			cap = CNT_W'(DEPTH);
		end else begin
			cap = capacity_q;
		end
	end

	assign cap_m1  = cap - CNT_W'(1);
	assign fend    = (fwd_q < cap) ? fwd_q : cap;
	assign rlo     = (rev_q >= cap) ? '0 : cap - rev_q;
	assign rev_wr  = cap_m1 - rev_q;
	assign full    = ({1'b0, fwd_q} + {1'b0, rev_q}) >= {1'b0, cap};
	assign enq_ok  = (op == MODE_ENQ) & ~full;
	assign deq_fwd = (op == MODE_DEQ) & ~side & (fwd_q != '0);
	assign deq_rev = (op == MODE_DEQ) & side & (rev_q != '0);

	// row of slot cells
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		always_comb begin
			ctrl[j].load       = acc & enq_ok &
			                     ((~side & (fwd_q == CNT_W'(j))) |
			                      (side & (rev_wr == CNT_W'(j))));
			ctrl[j].take_right = acc & deq_fwd & (CNT_W'(j + 1) < fend);
			ctrl[j].take_left  = acc & deq_rev & (CNT_W'(j) > rlo) &
			                     (CNT_W'(j) < cap);
			ctrl[j].in_fwd     = CNT_W'(j) < fend;
			ctrl[j].in_rev     = (CNT_W'(j) >= rlo) & (CNT_W'(j) < cap);
		end

		if (j == 0) begin : g_first
			assign lval[j] = '0;
		end else begin : g_mid_l
			assign lval[j] = val[j-1];
		end

		if (j == DEPTH - 1) begin : g_last
			assign rval[j] = '0;
		end else begin : g_mid_r
			assign rval[j] = val[j+1];
		end

		sbdf_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl[j]),
			.key   (data_in),
			.left  (lval[j]),
			.right (rval[j]),
			.value (val[j]),
			.hit   (hit[j])
		);
	end

	// result and next counts
	always_comb begin
		data_d   = '0;
		status_d = ST_OK;
		fidx_d   = '0;
		fside_d  = 1'b0;
		fwd_d    = fwd_q;
		rev_d    = rev_q;
		unique case (op)
			MODE_ENQ: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (!side) begin
					fwd_d = fwd_q + CNT_W'(1);
				end else begin
					rev_d = rev_q + CNT_W'(1);
				end
			end
			MODE_DEQ, MODE_PEEK: begin
				if ((side ? rev_q : fwd_q) == '0) begin
					status_d = ST_EMPTY;
				end else begin
					data_d = side ? val[cap_m1[IDX_W-1:0]] : val[0];
					if (deq_fwd) begin
						fwd_d = fwd_q - CNT_W'(1);
					end
					if (deq_rev) begin
						rev_d = rev_q - CNT_W'(1);
					end
				end
			end
			MODE_CLEAR: begin
				fwd_d = '0;
				rev_d = '0;
			end
			MODE_SEARCH: begin
				status_d = ST_NOTFOUND;
				// lowest matching slot wins
				for (int i = DEPTH - 1; i >= 0; i--) begin
					if (hit[i]) begin
						status_d = ST_OK;
						fidx_d   = IDX_W'(i);
						fside_d  = ~ctrl[i].in_fwd;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CNT_W'(DEPTH);
			fwd_q       <= '0;
			rev_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (acc) begin
				fwd_q       <= fwd_d;
				rev_q       <= rev_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (acc) begin
			data_out_q    <= data_d;
			status_q      <= status_d;
			found_index_q <= fidx_d;
			found_side_q  <= fside_d;
			fwd_out_q     <= fwd_d;
			rev_out_q     <= rev_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_out      = data_out_q;
	assign status        = status_q;
	assign found_index   = found_index_q;
	assign found_side    = found_side_q;
	assign forward_count = fwd_out_q;
	assign reverse_count = rev_out_q;

endmodule

`default_nettype wire

[hdl/sbdf_cell.sv]
// One buffer slot of the shared-buffer dual FIFO: holds a word, loads or
// shifts from a neighbor, and compares against the search key.
// Depends on sbdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbdf_cell (
	input  wire                            clk,
	input  wire sbdf_pkg::cell_ctrl_t      ctrl,
	input  wire  [sbdf_pkg::DATA_W-1:0]    key,
	input  wire  [sbdf_pkg::DATA_W-1:0]    left,
	input  wire  [sbdf_pkg::DATA_W-1:0]    right,
	output logic [sbdf_pkg::DATA_W-1:0]    value,
	output logic                           hit
);
	import sbdf_pkg::*;

	logic [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			value_q <= key;
		end else if (ctrl.take_right) begin
			value_q <= right;
		end else if (ctrl.take_left) begin
			value_q <= left;
		end else begin
			// hold
			value_q <= value_q;
		end
	end

	assign value = value_q;
	// only live entries may match
	assign hit   = (ctrl.in_fwd | ctrl.in_rev) & (value_q == key);

endmodule

`default_nettype wire

[dv/sbdf_reply_checker.sv]
// Checker for the shared-buffer dual FIFO: watches the config, input and result
// channels, predicts every reply and compares it with what the block returns.
// Depends on sbdf_pkg.
`timescale 1ns / 1ps

module sbdf_reply_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	input  wire                            cfg_ready,
	input  wire  [sbdf_pkg::CNT_W-1:0]     cfg_data,
	input  wire                            in_valid,
	input  wire                            in_stall,
	input  wire  [2:0]                     mode,
	input  wire                            side,
	input  wire  [sbdf_pkg::DATA_W-1:0]    data_in,
	input  wire                            out_valid,
	input  wire                            out_stall,
	input  wire  [sbdf_pkg::DATA_W-1:0]    data_out,
	input  wire  [1:0]                     status,
	input  wire  [sbdf_pkg::IDX_W-1:0]     found_index,
	input  wire                            found_side,
	input  wire  [sbdf_pkg::CNT_W-1:0]     forward_count,
	input  wire  [sbdf_pkg::CNT_W-1:0]     reverse_count,
	output int                             mismatches,
	output int                             replies_waiting
);
	import sbdf_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		status_t           st;
		logic [IDX_W-1:0]  idx;
		logic              fside;
		logic [CNT_W-1:0]  fcnt;
		logic [CNT_W-1:0]  rcnt;
	} reply_t;

	logic [DATA_W-1:0] slot_q [DEPTH];
	int                fwd_n;
	int                rev_n;
	logic [CNT_W-1:0]  cap_reg;
	reply_t            replies_due [$];
	reply_t            got;
	reply_t            want;
	int                bad;

	function automatic int cap_in_use();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return int'(cap_reg);
	endfunction

	function automatic reply_t compute_reply(input logic [2:0] op, input logic sd,
			input logic [DATA_W-1:0] x);
		reply_t r;
		int     cap;
		int     lo;
		int     fend;
		int     held;
		bit     hit;
		cap  = cap_in_use();
		r    = '0;
		r.st = ST_OK;
		case (op)
			MODE_ENQ: begin
				if (fwd_n + rev_n >= cap) begin
					r.st = ST_FULL;
				end else if (!sd) begin
					slot_q[fwd_n] = x;
					fwd_n++;
				end else begin
					slot_q[cap - 1 - rev_n] = x;
					rev_n++;
				end
			end
			MODE_DEQ, MODE_PEEK: begin
				held = sd ? rev_n : fwd_n;
				if (held == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.data = sd ? slot_q[cap - 1] : slot_q[0];
					if (op == MODE_DEQ) begin
						if (!sd) begin
							for (int i = 1; i < fwd_n && i < cap; i++)
								slot_q[i - 1] = slot_q[i];
							fwd_n--;
						end else begin
							lo = (rev_n >= cap) ? 0 : cap - rev_n;
							for (int i = cap - 1; i > lo; i--)
								slot_q[i] = slot_q[i - 1];
							rev_n--;
						end
					end
				end
			end
			MODE_CLEAR: begin
				fwd_n = 0;
				rev_n = 0;
			end
			MODE_SEARCH: begin
				// clip both regions to the slots in use; forward wins on overlap
				fend = (fwd_n < cap) ? fwd_n : cap;
				lo   = (rev_n >= cap) ? 0 : cap - rev_n;
				r.st = ST_NOTFOUND;
				hit  = 1'b0;
				for (int i = 0; i < cap && !hit; i++) begin
					if ((i < fend || i >= lo) && slot_q[i] == x) begin
						hit     = 1'b1;
						r.st    = ST_OK;
						r.idx   = IDX_W'(i);
						r.fside = (i >= fend);
					end
				end
			end
			default: ;
		endcase
		r.fcnt = CNT_W'(fwd_n);
		r.rcnt = CNT_W'(rev_n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_q[i])
				slot_q[i] = '0;
			fwd_n   = 0;
			rev_n   = 0;
			cap_reg = CNT_W'(DEPTH);
			replies_due.delete();
			bad     = 0;
			mismatches      <= 0;
			replies_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
			if (in_valid && !in_stall)
				replies_due.push_back(compute_reply(mode, side, data_in));
			if (out_valid && !out_stall) begin
				got.data  = data_out;
				got.st    = status_t'(status);
				got.idx   = found_index;
				got.fside = found_side;
				got.fcnt  = forward_count;
				got.rcnt  = reverse_count;
				if (replies_due.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%0t: reply with none pending: data %h status %0d", $realtime,
							got.data, got.st);
				end else begin
					want = replies_due.pop_front();
					if (got !== want) begin
						bad++;
						if (bad <= 10)
							$display("%0t: reply mismatch (exp/got) data %h/%h status %0d/%0d",
								$realtime, want.data, got.data, want.st, got.st,
								" index %0d/%0d side %0d/%0d fwd %0d/%0d rev %0d/%0d",
								want.idx, got.idx, want.fside, got.fside,
								want.fcnt, got.fcnt, want.rcnt, got.rcnt);
					end
				end
			end
			mismatches      <= bad;
			replies_waiting <= replies_due.size();
		end
	end

endmodule

[dv/tb.sv]
// Testbench top for the shared-buffer dual FIFO: clock, reset, stimulus with
// random idling and stalls, and the final verdict.
// Depends on sbdf_pkg, shared_buffer_dual_fifo and sbdf_reply_checker.
`timescale 1ns / 1ps

module tb;
	import sbdf_pkg::*;

	localparam int PHASE_ITEMS = 150;
	localparam int NUM_PHASES  = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 4;
	localparam logic [2:0] MODE_RSVD_LO = 3'd5;
	localparam logic [2:0] MODE_RSVD_HI = 3'd7;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CNT_W-1:0]  cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic [2:0]        mode      = '0;
	logic              side      = 1'b0;
	logic [DATA_W-1:0] data_in   = '0;
	logic              out_stall = 1'b0;

	wire               cfg_ready;
	wire               in_stall;
	wire               out_valid;
	wire [DATA_W-1:0]  data_out;
	wire [1:0]         status;
	wire [IDX_W-1:0]   found_index;
	wire               found_side;
	wire [CNT_W-1:0]   forward_count;
	wire [CNT_W-1:0]   reverse_count;

	int                mismatches;
	int                replies_waiting;
	bit                tx_burst = 1'b0;
	bit                rx_burst = 1'b0;
	bit                hold_req = 1'b0;
	logic [DATA_W-1:0] recent_vals [$];

	always #2 clk = ~clk;

	shared_buffer_dual_fifo dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.side          (side),
		.data_in       (data_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_out      (data_out),
		.status        (status),
		.found_index   (found_index),
		.found_side    (found_side),
		.forward_count (forward_count),
		.reverse_count (reverse_count)
	);

	sbdf_reply_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.side            (side),
		.data_in         (data_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.data_out        (data_out),
		.status          (status),
		.found_index     (found_index),
		.found_side      (found_side),
		.forward_count   (forward_count),
		.reverse_count   (reverse_count),
		.mismatches      (mismatches),
		.replies_waiting (replies_waiting)
	);

	task automatic send_item(input logic [2:0] op, input logic sd, input logic [DATA_W-1:0] x);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(16, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		side     <= sd;
		data_in  <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == MODE_ENQ) begin
			recent_vals.push_back(x);
			if (recent_vals.size() > 24)
				void'(recent_vals.pop_front());
		end
	endtask

	// drop valid, wait for every reply, then let the block settle
	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_waiting != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CNT_W-1:0] phase_capacity(input int p);
		case (p)
			0: return CNT_W'(1);
			1: return CNT_W'(DEPTH);
			2: return CNT_W'(0);
			3: return '1;
			4: return CNT_W'(2);
			default: return CNT_W'($urandom_range(31, 0));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(9, 0))
			0: begin
				case ($urandom_range(3, 0))
					0: return '0;
					1: return '1;
					2: return {1'b1, {(DATA_W - 1){1'b0}}};
					default: return {1'b0, {(DATA_W - 1){1'b1}}};
				endcase
			end
			// small pool so duplicates show up for search
			1, 2, 3: return DATA_W'($urandom_range(7, 0));
			default: return DATA_W'($urandom());
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_key();
		if (recent_vals.size() > 0 && $urandom_range(9, 0) < 7)
			return recent_vals[$urandom_range(recent_vals.size() - 1, 0)];
		return pick_word();
	endfunction

	task automatic random_item();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 40)
			send_item(MODE_ENQ, 1'($urandom), pick_word());
		else if (roll < 64)
			send_item(MODE_DEQ, 1'($urandom), pick_word());
		else if (roll < 74)
			send_item(MODE_PEEK, 1'($urandom), pick_word());
		else if (roll < 90)
			send_item(MODE_SEARCH, 1'($urandom), pick_key());
		else if (roll < 94)
			send_item(MODE_CLEAR, 1'($urandom), pick_word());
		else
			send_item(3'($urandom_range(MODE_RSVD_HI, MODE_RSVD_LO)), 1'($urandom), pick_word());
	endtask

	// result side: stall for a drawn number of cycles before each item
	initial begin
		int n;
		forever begin
			if (hold_req) begin
				n        = LONG_HOLD;
				hold_req = 1'b0;
			end else begin
				n = rx_burst ? 0 : $urandom_range(16, 0);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("shared_buffer_dual_fifo verification failed");
		$finish;
	end

	initial begin
		int p;
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queues
		send_item(MODE_DEQ, 1'b0, 32'h0000_0000);
		send_item(MODE_SEARCH, 1'b1, 32'h0000_002a);
		// fill both sides to full; this writes every slot once
		send_item(MODE_ENQ, 1'b0, 32'h7fff_ffff);
		send_item(MODE_ENQ, 1'b0, 32'h8000_0000);
		send_item(MODE_ENQ, 1'b0, 32'h0000_0000);
		send_item(MODE_ENQ, 1'b0, 32'hffff_ffff);
		send_item(MODE_ENQ, 1'b0, 32'h5555_5555);
		send_item(MODE_ENQ, 1'b0, 32'haaaa_aaaa);
		send_item(MODE_ENQ, 1'b0, 32'h0000_0001);
		send_item(MODE_ENQ, 1'b0, 32'h0000_002a);
		send_item(MODE_ENQ, 1'b1, 32'h0000_002a);
		send_item(MODE_ENQ, 1'b1, 32'h8000_0000);
		send_item(MODE_ENQ, 1'b1, 32'h1234_5678);
		send_item(MODE_ENQ, 1'b1, 32'hfedc_ba98);
		send_item(MODE_ENQ, 1'b1, 32'h0f0f_0f0f);
		send_item(MODE_ENQ, 1'b1, 32'hf0f0_f0f0);
		send_item(MODE_ENQ, 1'b1, 32'h3333_cccc);
		send_item(MODE_ENQ, 1'b1, 32'h0000_0007);
		send_item(MODE_ENQ, 1'b1, 32'h0000_0099);
		send_item(MODE_PEEK, 1'b1, 32'h0000_0000);
		send_item(MODE_DEQ, 1'b0, 32'h0000_0000);
		send_item(MODE_DEQ, 1'b1, 32'h0000_0000);
		send_item(MODE_SEARCH, 1'b0, 32'h8000_0000);
		send_item(MODE_SEARCH, 1'b0, 32'h0f0f_0f0f);
		send_item(MODE_RSVD_LO, 1'b1, 32'hffff_ffff);
		send_item(MODE_RSVD_HI, 1'b0, 32'h0000_0000);
		send_item(MODE_CLEAR, 1'b1, 32'hffff_ffff);

		for (p = 0; p < NUM_PHASES; p++) begin
			go_idle();
			write_capacity(phase_capacity(p));
			tx_burst = (p % 3 == 1);
			rx_burst = (p % 4 == 2);
			// every slot holds a written value, so keeping the counts is safe
			if (p != 4 && p != 7)
				send_item(MODE_CLEAR, 1'($urandom), pick_word());
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 2 && k == 20) begin
					tx_burst = 1'b1;
					rx_burst = 1'b0;
					hold_req = 1'b1;
				end
				if (p == 5 && k == PHASE_ITEMS / 2)
					go_idle();
				random_item();
			end
		end

		go_idle();
		if (mismatches == 0 && replies_waiting == 0)
			$display("shared_buffer_dual_fifo verification clean");
		else
			$display("shared_buffer_dual_fifo verification failed");
		$finish;
	end

endmodule

[files.f]
hdl/sbdf_pkg.sv
hdl/sbdf_cell.sv
hdl/shared_buffer_dual_fifo.sv
dv/sbdf_reply_checker.sv
dv/tb.sv
